// ----- src/mape_pkg.sv -----
// Shared types, codes and constants of the motion alarm progress engine.
package mape_pkg;

    // Default widths, handed to the top level parameters
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int TIMER_BITS_DEF  = 16;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int THR_W      = 10;
    localparam int THR_SQ_W   = 2 * THR_W;

    // Progress and counter widths
    localparam int PROG_W  = 7;
    localparam int COUNT_W = 8;

    // Progress arithmetic
    localparam logic [PROG_W-1:0] FULL_PROGRESS  = 7'd100;
    localparam logic [PROG_W-1:0] WARN_SPLIT     = 7'd25;
    localparam logic [PROG_W-1:0] RISE_BASE      = 7'd6;
    localparam logic [PROG_W-1:0] RISE_VIGILANT  = 7'd12;
    localparam logic [PROG_W-1:0] DECAY_BASE     = 7'd12;
    localparam logic [PROG_W-1:0] DECAY_VIGILANT = 7'd6;

    // Register reset values
    localparam logic                  SEVERITY_RST = 1'b0;
    localparam logic [THR_SQ_W-1:0]   THR_SQ_RST   = 20'd2500;   // 50 mg squared
    localparam logic [CFG_DATA_W-1:0] HOLDOFF_RST  = 16'd1000;
    localparam logic [CFG_DATA_W-1:0] DECAY_RST    = 16'd3000;
    localparam logic [CFG_DATA_W-1:0] EXTRA_RST    = 16'd12000;
    localparam logic [CFG_DATA_W-1:0] WINDOW_RST   = 16'd10000;

    typedef enum logic [1:0] {
        FUNC_SAMPLE = 2'd0,
        FUNC_TICK   = 2'd1,
        FUNC_MOTION = 2'd2,
        FUNC_CLEAR  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_MOVE  = 2'd1,
        EV_DECAY = 2'd2,
        EV_STOP  = 2'd3
    } event_t;

    typedef enum logic [1:0] {
        LVL_QUIET = 2'd0,
        LVL_LOW   = 2'd1,
        LVL_HIGH  = 2'd2,
        LVL_PANIC = 2'd3
    } level_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEVERITY = 3'd0,
        CFG_THRESH   = 3'd1,
        CFG_HOLDOFF  = 3'd2,
        CFG_DECAY    = 3'd3,
        CFG_EXTRA    = 3'd4,
        CFG_WINDOW   = 3'd5
    } cfg_idx_t;

    // Live configuration; the threshold is kept squared
    typedef struct packed {
        logic                  severity;
        logic [THR_SQ_W-1:0]   thr_sq;
        logic [CFG_DATA_W-1:0] holdoff;
        logic [CFG_DATA_W-1:0] decay;
        logic [CFG_DATA_W-1:0] extra;
        logic [CFG_DATA_W-1:0] window;
    } cfg_t;

    // Result of one beat, as seen after its state update
    typedef struct packed {
        logic [PROG_W-1:0]  progress;
        level_t             level;
        event_t             ev;
        logic               triggered;
        logic [COUNT_W-1:0] count;
        logic               stream;
    } res_t;

endpackage

// ----- src/motion_alarm_progress_engine.sv -----
// Top level of the motion alarm progress engine: beat registers and datapath.
//
// Takes one beat per clock while the result side keeps up, and returns
// exactly one result beat for it. The accepting edge loads the input
// register, which passes the beat on once the result register is free or read.
// Both sides may stall freely without losing throughput. The cycle time is set by
// the sample path: three high-pass filter updates, their squares, the sum of
// squares and the threshold compare feeding the progress update all sit
// between the input register and the result register. The squared threshold
// is formed when the threshold register is written. Configuration may only be
// written while no beat is in flight.
module motion_alarm_progress_engine #(
    parameter int SAMPLE_BITS = mape_pkg::SAMPLE_BITS_DEF,
    parameter int TIMER_BITS  = mape_pkg::TIMER_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration writes
    input  logic                            cfg_we,
    input  logic [mape_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mape_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // Input beats
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_func,
    input  logic signed [SAMPLE_BITS-1:0]   s_accel_x,
    input  logic signed [SAMPLE_BITS-1:0]   s_accel_y,
    input  logic signed [SAMPLE_BITS-1:0]   s_accel_z,
    input  logic                            s_armed,
    input  logic                            s_connected,
    // Result beats
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [mape_pkg::PROG_W-1:0]     m_progress,
    output logic [1:0]                      m_level,
    output logic [1:0]                      m_event_res,
    output logic                            m_triggered,
    output logic [mape_pkg::COUNT_W-1:0]    m_trigger_count,
    output logic                            m_stream_active
);

    localparam int FW    = SAMPLE_BITS + 6;
    localparam int SW    = 2 * FW;
    localparam int MAG_W = SW + 2;

    // Input register
    logic                   in_valid_reg;
    logic [1:0]             func_reg;
    logic [SAMPLE_BITS-1:0] x_reg, y_reg, z_reg;
    logic                   armed_reg, conn_reg;

    // Result register
    logic                   out_valid_reg;
    mape_pkg::res_t         res_reg;

    mape_pkg::cfg_t         cfg;
    mape_pkg::res_t         res;
    mape_pkg::func_t        func;
    logic                   advance;
    logic                   filt_upd;
    logic [SW-1:0]          sq_x, sq_y, sq_z;
    logic [MAG_W-1:0]       mag;
    logic                   win_open;

    // Handshake: input stage moves on when the result register frees up
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign func    = mape_pkg::func_t'(func_reg);

    // Samples feed the filters only while the window is open
    assign filt_upd = advance && (func == mape_pkg::FUNC_SAMPLE) && win_open;

    mape_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mape_axis_filter #(.SAMPLE_BITS(SAMPLE_BITS)) u_filt_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .upd     (filt_upd),
        .sample  (x_reg),
        .sq      (sq_x)
    );

    mape_axis_filter #(.SAMPLE_BITS(SAMPLE_BITS)) u_filt_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .upd     (filt_upd),
        .sample  (y_reg),
        .sq      (sq_y)
    );

    mape_axis_filter #(.SAMPLE_BITS(SAMPLE_BITS)) u_filt_z (
        .aclk    (aclk),
        .aresetn (aresetn),
        .upd     (filt_upd),
        .sample  (z_reg),
        .sq      (sq_z)
    );

    // Squared magnitude of the filtered vector
    assign mag = MAG_W'(sq_x) + MAG_W'(sq_y) + MAG_W'(sq_z);

    mape_alarm_ctrl #(.TIMER_BITS(TIMER_BITS), .MAG_W(MAG_W)) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .cfg       (cfg),
        .func      (func),
        .armed     (armed_reg),
        .connected (conn_reg),
        .mag       (mag),
        .win_open  (win_open),
        .res       (res)
    );

    // Input beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            func_reg  <= s_func;
            x_reg     <= s_accel_x;
            y_reg     <= s_accel_y;
            z_reg     <= s_accel_z;
            armed_reg <= s_armed;
            conn_reg  <= s_connected;
        end
    end

    // Result beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_progress      = res_reg.progress;
    assign m_level         = res_reg.level;
    assign m_event_res     = res_reg.ev;
    assign m_triggered     = res_reg.triggered;
    assign m_trigger_count = res_reg.count;
    assign m_stream_active = res_reg.stream;

    // Input stage only refuses while it holds a beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg)
        else $error("input stage stalled while empty");

    // Panic level goes with full progress
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_level == mape_pkg::LVL_PANIC) ==
                     (m_progress == mape_pkg::FULL_PROGRESS)))
        else $error("level and progress disagree");

    // Alarm-stop event only while the latch is held
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_event_res == mape_pkg::EV_STOP) |-> m_triggered)
        else $error("stop event without latched alarm");

endmodule

// ----- src/mape_cfg_regs.sv -----
// Configuration register file of the motion alarm progress engine.
module mape_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [mape_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mape_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output mape_pkg::cfg_t                   cfg
);

    mape_pkg::cfg_t                   cfg_reg;
    logic [mape_pkg::THR_W-1:0]       thr;
    logic [mape_pkg::THR_SQ_W-1:0]    thr_sq;

    // Square the threshold once at write time
    assign thr    = cfg_wdata[mape_pkg::THR_W-1:0];
    assign thr_sq = mape_pkg::THR_SQ_W'(thr) * mape_pkg::THR_SQ_W'(thr);

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.severity <= mape_pkg::SEVERITY_RST;
            cfg_reg.thr_sq   <= mape_pkg::THR_SQ_RST;
            cfg_reg.holdoff  <= mape_pkg::HOLDOFF_RST;
            cfg_reg.decay    <= mape_pkg::DECAY_RST;
            cfg_reg.extra    <= mape_pkg::EXTRA_RST;
            cfg_reg.window   <= mape_pkg::WINDOW_RST;
        end else if (cfg_we) begin
            case (mape_pkg::cfg_idx_t'(cfg_index))
                mape_pkg::CFG_SEVERITY: cfg_reg.severity <= cfg_wdata[0];
                mape_pkg::CFG_THRESH:   cfg_reg.thr_sq   <= thr_sq;
                mape_pkg::CFG_HOLDOFF:  cfg_reg.holdoff  <= cfg_wdata;
                mape_pkg::CFG_DECAY:    cfg_reg.decay    <= cfg_wdata;
                mape_pkg::CFG_EXTRA:    cfg_reg.extra    <= cfg_wdata;
                mape_pkg::CFG_WINDOW:   cfg_reg.window   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/mape_axis_filter.sv -----
// One axis: high-pass filter state and the square of the filtered value.
module mape_axis_filter #(
    parameter int SAMPLE_BITS = mape_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          upd,
    input  logic [SAMPLE_BITS-1:0]        sample,
    output logic [2*(SAMPLE_BITS+6)-1:0]  sq
);

    localparam int FW = SAMPLE_BITS + 6;   // filter width, 4 fraction bits
    localparam int SW = 2 * FW;

    logic [FW-1:0]          h_reg, h_next;
    logic [SAMPLE_BITS-1:0] prev_reg;
    logic [SAMPLE_BITS:0]   diff;
    logic [SAMPLE_BITS+4:0] diff16;
    logic [FW:0]            sum;
    logic [FW-1:0]          h_abs;

    // h = floor((h + 16*(x - prev)) / 2)
    assign diff   = {sample[SAMPLE_BITS-1], sample} - {prev_reg[SAMPLE_BITS-1], prev_reg};
    assign diff16 = {diff, 4'b0000};
    assign sum    = {h_reg[FW-1], h_reg} + {{2{diff16[SAMPLE_BITS+4]}}, diff16};
    assign h_next = sum[FW:1];

    // Magnitude term for this axis
    assign h_abs = h_next[FW-1] ? (~h_next + FW'(1)) : h_next;
    assign sq    = SW'(h_abs) * SW'(h_abs);

    // Filter state, only moves on an evaluated sample
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_reg    <= '0;
            prev_reg <= '0;
        end else if (upd) begin
            h_reg    <= h_next;
            prev_reg <= sample;
        end
    end

endmodule

// ----- src/mape_alarm_ctrl.sv -----
// Alarm progress, trigger latch, quiet timer and sample window state.
module mape_alarm_ctrl #(
    parameter int TIMER_BITS = mape_pkg::TIMER_BITS_DEF,
    parameter int MAG_W      = 46
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  mape_pkg::cfg_t     cfg,
    input  mape_pkg::func_t    func,
    input  logic               armed,
    input  logic               connected,
    input  logic [MAG_W-1:0]   mag,
    output logic               win_open,
    output mape_pkg::res_t     res
);

    localparam int CMP_W = (TIMER_BITS > mape_pkg::CFG_DATA_W + 1) ?
                           TIMER_BITS : mape_pkg::CFG_DATA_W + 1;

    logic [mape_pkg::PROG_W-1:0]  prog_reg, prog_next;
    logic                         latch_reg, latch_next;
    logic [mape_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [TIMER_BITS-1:0]        quiet_reg, quiet_next, quiet_inc;
    logic                         open_reg, open_next;
    logic [TIMER_BITS-1:0]        age_reg, age_next, age_inc;
    mape_pkg::event_t             ev;
    mape_pkg::level_t             level;

    logic [MAG_W-1:0]             thr_full;
    logic                         hit;
    logic [mape_pkg::PROG_W:0]    rise_sum;
    logic [mape_pkg::PROG_W-1:0]  rise, step;
    logic [CMP_W-1:0]             need;

    // Movement test: |h|^2 > (16*thr)^2, once the quiet time is past the holdoff
    assign thr_full = MAG_W'({cfg.thr_sq, 8'h00});
    assign hit      = (mag > thr_full) && (CMP_W'(quiet_reg) > CMP_W'(cfg.holdoff));

    assign rise     = cfg.severity ? mape_pkg::RISE_VIGILANT : mape_pkg::RISE_BASE;
    assign step     = cfg.severity ? mape_pkg::DECAY_VIGILANT : mape_pkg::DECAY_BASE;
    assign rise_sum = {1'b0, prog_reg} + {1'b0, rise};

    // Saturating timers
    assign quiet_inc = (quiet_reg == '1) ? quiet_reg : quiet_reg + TIMER_BITS'(1);
    assign age_inc   = (age_reg == '1) ? age_reg : age_reg + TIMER_BITS'(1);

    // Quiet time needed before a decay step
    assign need = CMP_W'(cfg.decay) +
                  ((prog_reg == mape_pkg::FULL_PROGRESS) ? CMP_W'(cfg.extra) : CMP_W'(0));

    // Current window state, gates the filter updates
    assign win_open = open_reg;

    // Next state for the beat in flight
    always_comb begin
        prog_next  = prog_reg;
        latch_next = latch_reg;
        count_next = count_reg;
        quiet_next = quiet_reg;
        open_next  = open_reg;
        age_next   = age_reg;
        ev         = mape_pkg::EV_NONE;
        case (func)
            mape_pkg::FUNC_SAMPLE: begin
                if (open_reg && hit) begin
                    ev         = mape_pkg::EV_MOVE;
                    quiet_next = '0;
                    if (armed && !connected) begin
                        prog_next = (rise_sum > {1'b0, mape_pkg::FULL_PROGRESS}) ?
                                    mape_pkg::FULL_PROGRESS :
                                    rise_sum[mape_pkg::PROG_W-1:0];
                    end
                    if (prog_next == mape_pkg::FULL_PROGRESS && !latch_reg) begin
                        latch_next = 1'b1;
                        if (count_reg != '1) begin
                            count_next = count_reg + mape_pkg::COUNT_W'(1);
                        end
                    end
                end
            end
            mape_pkg::FUNC_TICK: begin
                quiet_next = quiet_inc;
                if (!connected && armed && prog_reg != '0 &&
                    CMP_W'(quiet_inc) > need) begin
                    quiet_next = '0;
                    ev         = mape_pkg::EV_DECAY;
                    if (prog_reg <= step) begin
                        prog_next  = '0;
                        latch_next = 1'b0;
                    end else begin
                        prog_next = prog_reg - step;
                        if (latch_reg) begin
                            ev = mape_pkg::EV_STOP;
                        end
                    end
                end
                if (open_reg) begin
                    age_next = age_inc;
                    if (CMP_W'(age_inc) > CMP_W'(cfg.window)) begin
                        open_next = 1'b0;
                    end
                end
            end
            mape_pkg::FUNC_MOTION: begin
                if (!connected) begin
                    open_next = 1'b1;
                    age_next  = '0;
                end
            end
            mape_pkg::FUNC_CLEAR: begin
                prog_next  = '0;
                latch_next = 1'b0;
            end
            default: ;
        endcase
    end

    // Level from the updated progress
    always_comb begin
        if (prog_next == mape_pkg::FULL_PROGRESS) begin
            level = mape_pkg::LVL_PANIC;
        end else if (prog_next > mape_pkg::WARN_SPLIT) begin
            level = mape_pkg::LVL_HIGH;
        end else if (prog_next != '0) begin
            level = mape_pkg::LVL_LOW;
        end else begin
            level = mape_pkg::LVL_QUIET;
        end
    end

    assign res.progress  = prog_next;
    assign res.level     = level;
    assign res.ev        = ev;
    assign res.triggered = latch_next;
    assign res.count     = count_next;
    assign res.stream    = open_next;

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prog_reg  <= '0;
            latch_reg <= 1'b0;
            count_reg <= '0;
            quiet_reg <= '0;
            open_reg  <= 1'b0;
            age_reg   <= '0;
        end else if (advance) begin
            prog_reg  <= prog_next;
            latch_reg <= latch_next;
            count_reg <= count_next;
            quiet_reg <= quiet_next;
            open_reg  <= open_next;
            age_reg   <= age_next;
        end
    end

    // Progress never leaves its range
    assert property (@(posedge aclk) disable iff (!aresetn)
        prog_reg <= mape_pkg::FULL_PROGRESS)
        else $error("progress above full scale");

    // Trigger count only grows between resets
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> count_reg >= $past(count_reg))
        else $error("trigger count went down");

    // Any counted movement or decay step restarts the quiet timer
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && ev != mape_pkg::EV_NONE) |=> quiet_reg == '0)
        else $error("quiet timer not restarted");

endmodule

// ----- dv/motion_alarm_progress_engine_tb.sv -----
// Self-checking testbench of the motion alarm progress engine, with its own predictor.
`timescale 1ns / 100ps

module motion_alarm_progress_engine_tb;

    localparam int SAMPLE_W = mape_pkg::SAMPLE_BITS_DEF;
    localparam int TMR_W = mape_pkg::TIMER_BITS_DEF;
    localparam int HP_W = SAMPLE_W + 6;
    localparam logic [TMR_W-1:0] TIMER_MAX = '1;
    localparam logic [SAMPLE_W-1:0] ACC_MAX = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] ACC_MIN = 16'h8000;
    localparam int PCT_FULL = 100;
    localparam int PCT_WARN = 25;
    localparam int RISE_CALM = 6;
    localparam int RISE_ALERT = 12;
    localparam int DROP_CALM = 12;
    localparam int DROP_ALERT = 6;
    localparam int PHASES = 10;
    localparam int PHASE_BEATS = 53;
    localparam int MAX_GAP = 6;
    localparam int LONG_HOLD_AT = 150;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int SETTLE_CYCLES = 8;
    // The longest legal stretch without a handshake is the long receiver hold or
    // the settle and config burst between phases; the limit takes a wide margin.
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        mape_pkg::func_t      func;
        logic [SAMPLE_W-1:0]  ax;
        logic [SAMPLE_W-1:0]  ay;
        logic [SAMPLE_W-1:0]  az;
        logic                 armed;
        logic                 connected;
    } alarm_beat_t;

    // DUT ports
    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [mape_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [mape_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic [1:0]                      s_func = '0;
    logic [SAMPLE_W-1:0]             s_accel_x = '0;
    logic [SAMPLE_W-1:0]             s_accel_y = '0;
    logic [SAMPLE_W-1:0]             s_accel_z = '0;
    logic                            s_armed = 1'b0;
    logic                            s_connected = 1'b0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic [mape_pkg::PROG_W-1:0]     m_progress;
    logic [1:0]                      m_level;
    logic [1:0]                      m_event_res;
    logic                            m_triggered;
    logic [mape_pkg::COUNT_W-1:0]    m_trigger_count;
    logic                            m_stream_active;

    // Predictor copy of the configuration
    logic                            cfg_vigilant = 1'b0;
    logic [mape_pkg::THR_W-1:0]      cfg_thr_mg = 10'd50;
    logic [mape_pkg::CFG_DATA_W-1:0] cfg_holdoff = 16'd1000;
    logic [mape_pkg::CFG_DATA_W-1:0] cfg_decay = 16'd3000;
    logic [mape_pkg::CFG_DATA_W-1:0] cfg_extra = 16'd12000;
    logic [mape_pkg::CFG_DATA_W-1:0] cfg_window = 16'd10000;

    // Predictor copy of the block state
    logic signed [HP_W-1:0]      hp_acc [3] = '{default: '0};
    logic signed [SAMPLE_W-1:0]  prev_accel [3] = '{default: '0};
    logic [mape_pkg::PROG_W-1:0] alarm_pct = '0;
    logic                        latched = 1'b0;
    logic [mape_pkg::COUNT_W-1:0] trig_total = '0;
    logic [TMR_W-1:0]            quiet_ms = '0;
    logic                        win_open = 1'b0;
    logic [TMR_W-1:0]            win_age = '0;

    alarm_beat_t      stimulus_beats [$];
    mape_pkg::res_t   predicted_status [$];

    logic accept_in = 1'b0;
    logic accept_out = 1'b0;
    logic tx_steady = 1'b0;
    logic rx_steady = 1'b0;
    int   send_gap = 0;
    int   recv_wait = 0;
    int   stalled_cycles = 0;
    int   errors = 0;
    int   beats_taken = 0;
    int   results_seen = 0;
    int   moves_seen = 0;
    int   decays_seen = 0;
    int   stops_seen = 0;
    int   peak_count = 0;

    motion_alarm_progress_engine uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_accel_x       (s_accel_x),
        .s_accel_y       (s_accel_y),
        .s_accel_z       (s_accel_z),
        .s_armed         (s_armed),
        .s_connected     (s_connected),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_progress      (m_progress),
        .m_level         (m_level),
        .m_event_res     (m_event_res),
        .m_triggered     (m_triggered),
        .m_trigger_count (m_trigger_count),
        .m_stream_active (m_stream_active)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Advance the alarm state by one beat and return the status it reports
    function automatic mape_pkg::res_t predict_alarm_status(input alarm_beat_t b);
        mape_pkg::res_t   r;
        mape_pkg::event_t ev;
        longint x, h, mag, lim, need;
        int     nxt, i;
        logic signed [SAMPLE_W-1:0] axis [3];
        ev = mape_pkg::EV_NONE;
        axis[0] = b.ax;
        axis[1] = b.ay;
        axis[2] = b.az;
        case (b.func)
            mape_pkg::FUNC_SAMPLE: begin
                // samples outside the window leave the filter untouched
                if (win_open) begin
                    mag = 0;
                    for (i = 0; i < 3; i++) begin
                        x = longint'(axis[i]);
                        h = (longint'(hp_acc[i]) + (x - longint'(prev_accel[i])) * 16) >>> 1;
                        hp_acc[i] = h[HP_W-1:0];
                        prev_accel[i] = axis[i];
                        mag += h * h;
                    end
                    lim = longint'(cfg_thr_mg) * 16;
                    if (mag > lim * lim && quiet_ms > cfg_holdoff) begin
                        ev = mape_pkg::EV_MOVE;
                        quiet_ms = '0;
                        if (!b.connected && b.armed) begin
                            nxt = int'(alarm_pct) + (cfg_vigilant ? RISE_ALERT : RISE_CALM);
                            if (nxt > PCT_FULL) nxt = PCT_FULL;
                            alarm_pct = nxt[mape_pkg::PROG_W-1:0];
                        end
                        if (alarm_pct == PCT_FULL && !latched) begin
                            latched = 1'b1;
                            if (trig_total != '1) trig_total++;
                        end
                    end
                end
            end
            mape_pkg::FUNC_TICK: begin
                if (quiet_ms != TIMER_MAX) quiet_ms++;
                need = longint'(cfg_decay);
                if (alarm_pct == PCT_FULL) need += longint'(cfg_extra);
                if (!b.connected && longint'(quiet_ms) > need && b.armed && alarm_pct != 0) begin
                    nxt = int'(alarm_pct) - (cfg_vigilant ? DROP_ALERT : DROP_CALM);
                    quiet_ms = '0;
                    ev = mape_pkg::EV_DECAY;
                    if (nxt <= 0) begin
                        alarm_pct = '0;
                        latched = 1'b0;
                    end else begin
                        alarm_pct = nxt[mape_pkg::PROG_W-1:0];
                        if (latched && alarm_pct < PCT_FULL) ev = mape_pkg::EV_STOP;
                    end
                end
                // window ages only while open
                if (win_open) begin
                    if (win_age != TIMER_MAX) win_age++;
                    if (win_age > cfg_window) win_open = 1'b0;
                end
            end
            mape_pkg::FUNC_MOTION: begin
                if (!b.connected) begin
                    win_open = 1'b1;
                    win_age = '0;
                end
            end
            default: begin
                alarm_pct = '0;
                latched = 1'b0;
            end
        endcase
        r.progress = alarm_pct;
        if (alarm_pct == PCT_FULL) r.level = mape_pkg::LVL_PANIC;
        else if (alarm_pct > PCT_WARN) r.level = mape_pkg::LVL_HIGH;
        else if (alarm_pct != 0) r.level = mape_pkg::LVL_LOW;
        else r.level = mape_pkg::LVL_QUIET;
        r.ev = ev;
        r.triggered = latched;
        r.count = trig_total;
        r.stream = win_open;
        return r;
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Monitor: predict on accepted input beats, check accepted result beats
    always @(posedge aclk) begin : monitor
        mape_pkg::res_t want;
        alarm_beat_t    seen;
        accept_in = aresetn && s_valid && s_ready;
        accept_out = aresetn && m_valid && m_ready;
        if (accept_in) begin
            seen.func = mape_pkg::func_t'(s_func);
            seen.ax = s_accel_x;
            seen.ay = s_accel_y;
            seen.az = s_accel_z;
            seen.armed = s_armed;
            seen.connected = s_connected;
            predicted_status.push_back(predict_alarm_status(seen));
            beats_taken++;
        end
        if (accept_out) begin
            results_seen++;
            if (m_event_res == mape_pkg::EV_MOVE) moves_seen++;
            if (m_event_res == mape_pkg::EV_DECAY) decays_seen++;
            if (m_event_res == mape_pkg::EV_STOP) stops_seen++;
            if (int'(m_trigger_count) > peak_count) peak_count = int'(m_trigger_count);
            if (predicted_status.size() == 0) begin
                errors++;
                $display("%0t: result beat with nothing predicted, actual progress %0d",
                         $time, m_progress);
            end else begin
                want = predicted_status.pop_front();
                compare_field("progress", int'(want.progress), int'(m_progress));
                compare_field("level", int'(want.level), int'(m_level));
                compare_field("event_res", int'(want.ev), int'(m_event_res));
                compare_field("triggered", int'(want.triggered), int'(m_triggered));
                compare_field("trigger_count", int'(want.count), int'(m_trigger_count));
                compare_field("stream_active", int'(want.stream), int'(m_stream_active));
            end
        end
    end

    // Driver: presents queued beats with a random gap before each, none when steady
    always @(negedge aclk) begin : sender
        alarm_beat_t b;
        if (aresetn && !(s_valid && !accept_in)) begin
            if (s_valid) send_gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
            if (send_gap == 0 && stimulus_beats.size() != 0) begin
                b = stimulus_beats.pop_front();
                s_func <= b.func;
                s_accel_x <= b.ax;
                s_accel_y <= b.ay;
                s_accel_z <= b.az;
                s_armed <= b.armed;
                s_connected <= b.connected;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
                if (send_gap != 0) send_gap--;
            end
        end
    end

    // Result sink: random stalls, plus one long hold to back the block up
    always @(negedge aclk) begin : receiver
        if (aresetn) begin
            if (accept_out) begin
                recv_wait = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
                if (results_seen == LONG_HOLD_AT) recv_wait = LONG_HOLD_CYCLES;
            end
            if (recv_wait != 0) begin
                m_ready <= 1'b0;
                recv_wait--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog on handshake progress
    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready)) stalled_cycles <= 0;
        else stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, stalled_cycles, predicted_status.size());
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [SAMPLE_W-1:0] pick_accel();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5) return SAMPLE_W'($urandom);
        if (sel < 8) return SAMPLE_W'($urandom_range(0, 128) - 64);
        case ($urandom_range(0, 3))
            0: return ACC_MAX;
            1: return ACC_MIN;
            2: return '0;
            default: return '1;
        endcase
    endfunction

    function automatic alarm_beat_t fixed_beat(input mape_pkg::func_t f,
                                               input logic [SAMPLE_W-1:0] x,
                                               input logic [SAMPLE_W-1:0] y,
                                               input logic [SAMPLE_W-1:0] z,
                                               input logic arm, input logic link);
        alarm_beat_t b;
        b.func = f;
        b.ax = x;
        b.ay = y;
        b.az = z;
        b.armed = arm;
        b.connected = link;
        return b;
    endfunction

    function automatic alarm_beat_t make_beat(input mape_pkg::func_t f, input logic arm,
                                              input logic link);
        return fixed_beat(f, pick_accel(), pick_accel(), pick_accel(), arm, link);
    endfunction

    function automatic int pick_setting(input int lo, input int hi, input int top);
        int roll;
        roll = $urandom_range(0, 7);
        if (roll == 0) return 0;
        if (roll == 1) return top;
        return $urandom_range(lo, hi);
    endfunction

    // Register write; the predictor copy follows at once since nothing is in flight
    task automatic write_reg(input mape_pkg::cfg_idx_t idx, input int value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[mape_pkg::CFG_DATA_W-1:0];
        case (idx)
            mape_pkg::CFG_SEVERITY: cfg_vigilant = value[0];
            mape_pkg::CFG_THRESH:   cfg_thr_mg = value[mape_pkg::THR_W-1:0];
            mape_pkg::CFG_HOLDOFF:  cfg_holdoff = value[mape_pkg::CFG_DATA_W-1:0];
            mape_pkg::CFG_DECAY:    cfg_decay = value[mape_pkg::CFG_DATA_W-1:0];
            mape_pkg::CFG_EXTRA:    cfg_extra = value[mape_pkg::CFG_DATA_W-1:0];
            mape_pkg::CFG_WINDOW:   cfg_window = value[mape_pkg::CFG_DATA_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(input int sev, input int thr, input int hold,
                             input int dec, input int ext, input int win);
        write_reg(mape_pkg::CFG_SEVERITY, sev);
        write_reg(mape_pkg::CFG_THRESH, thr);
        write_reg(mape_pkg::CFG_HOLDOFF, hold);
        write_reg(mape_pkg::CFG_DECAY, dec);
        write_reg(mape_pkg::CFG_EXTRA, ext);
        write_reg(mape_pkg::CFG_WINDOW, win);
    endtask

    task automatic drain();
        while (stimulus_beats.size() != 0 || s_valid || predicted_status.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Mostly well-formed bursts (interrupt, then samples, ticks and rare clears), some noise
    task automatic queue_phase(input int count);
        int              left, run, k, roll;
        mape_pkg::func_t f;
        left = count;
        while (left > 0) begin
            if ($urandom_range(0, 99) < 85) begin
                stimulus_beats.push_back(make_beat(mape_pkg::FUNC_MOTION, 1'b1, 1'b0));
                left--;
                run = $urandom_range(3, 12);
                for (k = 0; k < run && left > 0; k++) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 55) f = mape_pkg::FUNC_SAMPLE;
                    else if (roll < 98) f = mape_pkg::FUNC_TICK;
                    else f = mape_pkg::FUNC_CLEAR;
                    stimulus_beats.push_back(make_beat(f, $urandom_range(0, 9) != 0,
                                                       $urandom_range(0, 9) == 0));
                    left--;
                end
            end else begin
                stimulus_beats.push_back(make_beat(mape_pkg::func_t'($urandom_range(0, 3)),
                                                   1'($urandom_range(0, 1)),
                                                   1'($urandom_range(0, 1))));
                left--;
            end
        end
    endtask

    initial begin : run_sequence
        int p, k;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings: closed-window sample, interrupt while linked, open, held-off sample, tick
        @(posedge aclk);
        stimulus_beats.push_back(fixed_beat(mape_pkg::FUNC_SAMPLE, ACC_MAX, ACC_MIN, '0,
                                            1'b1, 1'b0));
        stimulus_beats.push_back(fixed_beat(mape_pkg::FUNC_MOTION, '0, '0, '0, 1'b1, 1'b1));
        stimulus_beats.push_back(fixed_beat(mape_pkg::FUNC_MOTION, '0, '0, '0, 1'b1, 1'b0));
        stimulus_beats.push_back(fixed_beat(mape_pkg::FUNC_SAMPLE, ACC_MIN, ACC_MAX, ACC_MIN,
                                            1'b1, 1'b0));
        stimulus_beats.push_back(fixed_beat(mape_pkg::FUNC_TICK, '0, '0, '0, 1'b1, 1'b0));
        drain();

        // Vigilant, zero threshold and holdoff: full-scale swings climb to the latch,
        // then two quiet ticks decay it and the alarm stops sounding, then clear
        configure(1, 0, 0, 1, 0, 65535);
        @(posedge aclk);
        for (k = 0; k < 9; k++) begin
            if (k % 2 == 0)
                stimulus_beats.push_back(fixed_beat(mape_pkg::FUNC_SAMPLE, ACC_MAX, ACC_MIN,
                                                    ACC_MAX, 1'b1, 1'b0));
            else
                stimulus_beats.push_back(fixed_beat(mape_pkg::FUNC_SAMPLE, ACC_MIN, ACC_MAX,
                                                    ACC_MIN, 1'b1, 1'b0));
            if (k != 8)
                stimulus_beats.push_back(fixed_beat(mape_pkg::FUNC_TICK, ACC_MAX, ACC_MAX,
                                                    ACC_MAX, 1'b0, 1'b1));
        end
        stimulus_beats.push_back(fixed_beat(mape_pkg::FUNC_TICK, '0, '0, '0, 1'b1, 1'b0));
        stimulus_beats.push_back(fixed_beat(mape_pkg::FUNC_TICK, '0, '0, '0, 1'b1, 1'b0));
        stimulus_beats.push_back(fixed_beat(mape_pkg::FUNC_CLEAR, '1, '1, '1, 1'b1, 1'b1));
        drain();

        // Random phases, each under its own register setting
        for (p = 1; p <= PHASES; p++) begin
            tx_steady = (p % 3 == 0);
            rx_steady = (p % 4 == 1);
            if (p == 1)
                configure(0, 0, 0, 0, 0, 0);
            else if (p == 2)
                configure(1, 1023, 65535, 65535, 65535, 65535);
            else
                configure($urandom_range(0, 1), pick_setting(0, 120, 1023),
                          pick_setting(0, 6, 65535), pick_setting(1, 12, 65535),
                          pick_setting(0, 20, 65535), pick_setting(4, 40, 65535));
            @(posedge aclk);
            queue_phase(PHASE_BEATS);
            drain();
        end

        $display("Covered %0d beats over %0d register settings, %0d results checked.",
                 beats_taken, PHASES + 2, results_seen);
        $display("Movements %0d, decay steps %0d, alarm stops %0d, peak trigger count %0d.",
                 moves_seen, decays_seen, stops_seen, peak_count);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- motion_alarm_progress_engine.f -----
src/mape_pkg.sv
src/mape_cfg_regs.sv
src/mape_axis_filter.sv
src/mape_alarm_ctrl.sv
src/motion_alarm_progress_engine.sv
dv/motion_alarm_progress_engine_tb.sv
